// ===== rtl/csvt_pkg.sv =====
// ---------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the separated-value field tokeniser.
// ---------------------------------------------------------------------------
package csvt_pkg;

    // whitespace and separator slots packed into one 32-bit register
    localparam int CHAR_SLOTS  = 4;
    localparam int MAX_COLUMNS = 65535;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] NL_CHAR     = 8'h0A;
    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] BSLASH_CHAR = 8'h5C;

    localparam logic [15:0] COLS_LIMIT =
        (MAX_COLUMNS > 65535) ? 16'hFFFF : 16'(MAX_COLUMNS);
    localparam logic [2:0] SLOT_LIMIT =
        (CHAR_SLOTS > 4) ? 3'd4 : 3'(CHAR_SLOTS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_CHARS     = 3'd0,
        CFG_WHITE_COUNT     = 3'd1,
        CFG_SEP_CHARS       = 3'd2,
        CFG_SEP_COUNT       = 3'd3,
        CFG_SKIP_LINES      = 3'd4,
        CFG_ROWS_TO_READ    = 3'd5,
        CFG_COLUMNS_PER_ROW = 3'd6,
        CFG_STOP_ON_ERROR   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        EV_CHAR           = 3'd0,
        EV_FIELD_END      = 3'd1,
        EV_ROW_END        = 3'd2,
        EV_SHORT_LINE     = 3'd3,
        EV_UNEXPECTED_END = 3'd4
    } ev_kind_t;

    typedef enum logic [2:0] {
        MODE_SKIP  = 3'd0,
        MODE_LEAD  = 3'd1,
        MODE_ITEM  = 3'd2,
        MODE_QUOTE = 3'd3,
        MODE_QESC  = 3'd4,
        MODE_TRAIL = 3'd5,
        MODE_HALT  = 3'd6
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        ev_kind_t    event_kind;
        logic [7:0]  char_value;
        logic        empty_field;
        logic [15:0] column_index;
        logic [23:0] row_index;
        logic        last_of_run;
    } out_item_t;

    // all events caused by one input byte, in output order
    typedef struct packed {
        logic [1:0]          count;
        out_item_t [2:0]     ev;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // membership of a byte in a packed character set, newline never matches
    function automatic logic in_set(input logic [7:0] b, input logic [31:0] chars,
                                    input logic [2:0] count);
        logic [2:0] n;
        logic       hit;
        n   = (count > SLOT_LIMIT) ? SLOT_LIMIT : count;
        hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < n) && (chars[8*i +: 8] == b)) begin
                hit = 1'b1;
            end
        end
        return hit && (b != NL_CHAR);
    endfunction

endpackage

// ===== rtl/csvt_front.sv =====
// ---------------------------------------------------------------------------
// csvt_front
// Configuration registers and the per-byte parse decision; an accepted
// byte yields at most one bundle, of up to three events, for the queue.
// ---------------------------------------------------------------------------
module csvt_front #(
    parameter int MAX_ITEM_CHARS = 255
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [csvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               in_fire,
    input  csvt_pkg::in_item_t                 in_data,
    output logic                               push,
    output csvt_pkg::bundle_t                  bundle
);
    import csvt_pkg::*;

    localparam int LEN_W = $clog2(MAX_ITEM_CHARS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ITEM_CHARS);

    // configuration
    logic [31:0] white_chars_reg;
    logic [2:0]  white_count_reg;
    logic [31:0] sep_chars_reg;
    logic [2:0]  sep_count_reg;
    logic [23:0] skip_lines_reg;
    logic [23:0] rows_to_read_reg;
    logic [15:0] columns_per_row_reg;
    logic        stop_on_error_reg;

    // parse state
    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] item_length_reg, item_length_next;
    logic [15:0]      column_count_reg, column_count_next;
    logic [23:0]      row_count_reg, row_count_next;
    logic [23:0]      skipped_count_reg, skipped_count_next;
    logic             field_has_text_reg, field_has_text_next;

    // per-byte decision
    mode_t       mode_eff;
    logic [7:0]  b;
    logic        is_nl, is_white, is_sep, is_quote, is_bslash;
    logic [15:0] cols_eff;
    logic [15:0] cc_inc;
    logic [23:0] rc_inc;
    logic        do_close, term_nl, lead_after, lead_item;
    logic        ev_fe, ev_short, ev_row, ev_char, ev_unexp, fe_empty;
    logic [1:0]  n;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_chars_reg     <= 32'd32;
            white_count_reg     <= 3'd1;
            sep_chars_reg       <= 32'h0009_2C3B;
            sep_count_reg       <= 3'd3;
            skip_lines_reg      <= 24'd0;
            rows_to_read_reg    <= 24'd0;
            columns_per_row_reg <= 16'd1;
            stop_on_error_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_WHITE_CHARS:     white_chars_reg     <= cfg_wdata;
                CFG_WHITE_COUNT:     white_count_reg     <= cfg_wdata[2:0];
                CFG_SEP_CHARS:       sep_chars_reg       <= cfg_wdata;
                CFG_SEP_COUNT:       sep_count_reg       <= cfg_wdata[2:0];
                CFG_SKIP_LINES:      skip_lines_reg      <= cfg_wdata[23:0];
                CFG_ROWS_TO_READ:    rows_to_read_reg    <= cfg_wdata[23:0];
                CFG_COLUMNS_PER_ROW: columns_per_row_reg <= cfg_wdata[15:0];
                CFG_STOP_ON_ERROR:   stop_on_error_reg   <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // parse state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_SKIP;
            item_length_reg    <= '0;
            column_count_reg   <= '0;
            row_count_reg      <= '0;
            skipped_count_reg  <= '0;
            field_has_text_reg <= 1'b0;
        end else begin
            mode_reg           <= mode_next;
            item_length_reg    <= item_length_next;
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
            skipped_count_reg  <= skipped_count_next;
            field_has_text_reg <= field_has_text_next;
        end
    end

    // byte classification
    always_comb begin
        b         = in_data.byte_in;
        is_nl     = (b == NL_CHAR);
        is_quote  = (b == QUOTE_CHAR);
        is_bslash = (b == BSLASH_CHAR);
        is_white  = in_set(b, white_chars_reg, white_count_reg);
        is_sep    = in_set(b, sep_chars_reg, sep_count_reg);
        cols_eff  = (columns_per_row_reg > COLS_LIMIT) ? COLS_LIMIT : columns_per_row_reg;
        cc_inc    = column_count_reg + 16'd1;
        rc_inc    = row_count_reg + 24'd1;
    end

    // next state and event flags
    always_comb begin
        mode_eff = (mode_reg == MODE_SKIP && skipped_count_reg >= skip_lines_reg) ?
                   MODE_LEAD : mode_reg;
        mode_next           = mode_reg;
        item_length_next    = item_length_reg;
        column_count_next   = column_count_reg;
        row_count_next      = row_count_reg;
        skipped_count_next  = skipped_count_reg;
        field_has_text_next = field_has_text_reg;
        do_close   = 1'b0;
        term_nl    = 1'b0;
        lead_after = 1'b0;
        lead_item  = 1'b0;
        ev_fe      = 1'b0;
        ev_short   = 1'b0;
        ev_row     = 1'b0;
        ev_char    = 1'b0;
        ev_unexp   = 1'b0;
        fe_empty   = 1'b0;
        if (in_fire) begin
            mode_next = mode_eff;
            if (mode_eff == MODE_HALT) begin
                mode_next = MODE_HALT;
            end else if (in_data.end_of_stream) begin
                // silent stop only at a clean row start in read-to-end mode
                ev_unexp  = !(mode_eff == MODE_LEAD && column_count_reg == 16'd0 &&
                              rows_to_read_reg == 24'd0);
                mode_next = MODE_HALT;
            end else begin
                case (mode_eff)
                    MODE_SKIP: begin
                        if (is_nl) begin
                            skipped_count_next = skipped_count_reg + 24'd1;
                        end
                    end
                    MODE_LEAD: begin
                        if (is_nl) begin
                            do_close = 1'b1;
                            term_nl  = 1'b1;
                        end else if (is_white) begin
                            mode_next = MODE_LEAD;
                        end else if (is_quote) begin
                            mode_next = MODE_QUOTE;
                        end else if (is_sep) begin
                            do_close = 1'b1;
                        end else begin
                            lead_item = 1'b1;
                        end
                    end
                    MODE_ITEM: begin
                        if (is_nl) begin
                            do_close = 1'b1;
                            term_nl  = 1'b1;
                        end else if (is_white) begin
                            mode_next = MODE_TRAIL;
                        end else if (is_sep) begin
                            do_close = 1'b1;
                        end else if (item_length_reg < LEN_MAX) begin
                            item_length_next = item_length_reg + LEN_W'(1);
                            ev_char          = 1'b1;
                        end
                    end
                    MODE_QUOTE: begin
                        if (is_nl) begin
                            do_close = 1'b1;
                            term_nl  = 1'b1;
                        end else if (is_bslash) begin
                            mode_next = MODE_QESC;
                        end else if (is_quote) begin
                            mode_next = MODE_TRAIL;
                        end
                    end
                    MODE_QESC: begin
                        if (is_nl) begin
                            do_close = 1'b1;
                            term_nl  = 1'b1;
                        end else begin
                            mode_next = MODE_QUOTE;
                        end
                    end
                    MODE_TRAIL: begin
                        if (is_nl) begin
                            do_close = 1'b1;
                            term_nl  = 1'b1;
                        end else if (is_sep && !is_white) begin
                            do_close = 1'b1;
                        end else if (!is_white) begin
                            // a new item after trailing blanks closes the field first
                            do_close   = 1'b1;
                            lead_after = 1'b1;
                        end
                    end
                    default: mode_next = MODE_HALT;
                endcase

                // field close, with optional short line and row end
                if (do_close) begin
                    ev_fe               = 1'b1;
                    fe_empty            = !field_has_text_reg;
                    field_has_text_next = 1'b0;
                    item_length_next    = '0;
                    mode_next           = MODE_LEAD;
                    column_count_next   = cc_inc;
                    if (term_nl) begin
                        if (cc_inc < cols_eff) begin
                            ev_short = 1'b1;
                            if (stop_on_error_reg) begin
                                mode_next = MODE_HALT;
                            end
                        end
                        ev_row = !(ev_short && stop_on_error_reg);
                    end else begin
                        ev_row = (cc_inc >= cols_eff);
                    end
                    if (ev_row) begin
                        column_count_next = 16'd0;
                        row_count_next    = rc_inc;
                        if (rows_to_read_reg != 24'd0 && rc_inc >= rows_to_read_reg) begin
                            mode_next = MODE_HALT;
                        end
                    end
                    if (lead_after && mode_next == MODE_LEAD) begin
                        if (is_quote) begin
                            mode_next = MODE_QUOTE;
                        end else begin
                            lead_item = 1'b1;
                        end
                    end
                end

                // first character of an item
                if (lead_item) begin
                    mode_next           = MODE_ITEM;
                    field_has_text_next = 1'b1;
                    item_length_next    = LEN_W'(1);
                    ev_char             = 1'b1;
                end
            end
        end
    end

    // pack the events in order
    always_comb begin
        bundle = '0;
        n      = 2'd0;
        if (ev_unexp) begin
            bundle.ev[n].event_kind   = EV_UNEXPECTED_END;
            bundle.ev[n].column_index = column_count_reg;
            bundle.ev[n].row_index    = row_count_reg;
            n = n + 2'd1;
        end
        if (ev_fe) begin
            bundle.ev[n].event_kind   = EV_FIELD_END;
            bundle.ev[n].empty_field  = fe_empty;
            bundle.ev[n].column_index = cc_inc;
            bundle.ev[n].row_index    = row_count_reg;
            n = n + 2'd1;
        end
        if (ev_short) begin
            bundle.ev[n].event_kind   = EV_SHORT_LINE;
            bundle.ev[n].column_index = cc_inc;
            bundle.ev[n].row_index    = row_count_reg;
            n = n + 2'd1;
        end
        if (ev_row) begin
            bundle.ev[n].event_kind   = EV_ROW_END;
            bundle.ev[n].column_index = cc_inc;
            bundle.ev[n].row_index    = row_count_reg;
            n = n + 2'd1;
        end
        if (ev_char) begin
            bundle.ev[n].event_kind   = EV_CHAR;
            bundle.ev[n].char_value   = b;
            bundle.ev[n].column_index = column_count_next;
            bundle.ev[n].row_index    = row_count_next;
            n = n + 2'd1;
        end
        if (n != 2'd0) begin
            bundle.ev[n - 2'd1].last_of_run = 1'b1;
        end
        bundle.count = n;
        push         = in_fire && (n != 2'd0);
    end

    // halt is final until reset
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("parser left halt without reset");

    // a halted parser produces nothing
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && mode_reg == MODE_HALT) |-> !push)
        else $error("events produced while halted");

endmodule

// ===== rtl/csvt_queue.sv =====
// ---------------------------------------------------------------------------
// csvt_queue
// Small first-in first-out store of event bundles between parser and
// output sequencer.
// ---------------------------------------------------------------------------
module csvt_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  csvt_pkg::bundle_t      push_data,
    input  logic                   pop,
    output csvt_pkg::bundle_t      head,
    output csvt_pkg::q_status_t    stat
);
    import csvt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bundle_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
        head       = mem_reg[rd_ptr_reg];
        stat.full  = (count_reg == CNT_FULL);
        stat.empty = (count_reg == '0);
    end

    // no overflow and no underflow
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("bundle queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("bundle queue underflow");

endmodule

// ===== rtl/csvt_back.sv =====
// ---------------------------------------------------------------------------
// csvt_back
// Output sequencer: walks the head bundle one event per cycle into the
// result register, holding while m_valid is high and m_ready is low.
// ---------------------------------------------------------------------------
module csvt_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  csvt_pkg::bundle_t      head,
    input  csvt_pkg::q_status_t    stat,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output csvt_pkg::out_item_t    m_data
);
    import csvt_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;

    // event pick and output register load
    always_comb begin
        load           = !stat.empty && (!out_valid_reg || m_ready);
        pop            = load && (idx_reg == head.count - 2'd1);
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (load) begin
            out_next       = head.ev[idx_reg];
            out_valid_next = 1'b1;
            idx_next       = pop ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // walk index stays inside the head bundle
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.empty |-> idx_reg < head.count)
        else $error("event index past bundle end");

    // the bundle is released exactly on its final event
    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (pop == head.ev[idx_reg].last_of_run))
        else $error("bundle released off its final event");

endmodule

// ===== rtl/csv_field_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// csv_field_tokenizer_top
// Byte-serial tokeniser for separated-value text: parse stage, bundle
// queue and output sequencer.
// ---------------------------------------------------------------------------
// path: a byte's events pass the bundle queue, then the output register
// throughput: one byte per cycle while m_ready is high and each byte yields
//   at most one event; a byte with k events holds the single output register
//   until all k have left; the QUEUE_DEPTH bundle queue absorbs the bursts
// reset: synchronous active-low aresetn restores register defaults, parse
//   state, and empties queue and output; no clearing pass
module csv_field_tokenizer_top #(
    parameter int MAX_ITEM_CHARS = 255,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [csvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  csvt_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output csvt_pkg::out_item_t                m_data
);
    import csvt_pkg::*;

    logic      in_fire;
    logic      push;
    logic      pop;
    bundle_t   bundle;
    bundle_t   head;
    q_status_t stat;

    // input transfer whenever the queue has room
    assign s_ready = !stat.full;
    assign in_fire = s_valid && s_ready;

    csvt_front #(
        .MAX_ITEM_CHARS (MAX_ITEM_CHARS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_data   (s_data),
        .push      (push),
        .bundle    (bundle)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (bundle),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    csvt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
